// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked and disabled during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/fsm_pkg.sv
// ---------------------------------------------------------------------------
// fsm_pkg
// types and codes shared by the substring match core and its cells
// ---------------------------------------------------------------------------
package fsm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] symbol;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [15:0] position;
    } t_out_word;

    // control broadcast to one cell
    typedef struct packed {
        logic       restart;
        logic       step;
        logic       load;
        logic [7:0] symbol;
    } t_cell_ctrl;

endpackage

// File: src/fsm_cell.sv
// ---------------------------------------------------------------------------
// fsm_cell
// one pattern byte and its partial match flag
// ---------------------------------------------------------------------------
module fsm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsm_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_prev_flag,
    output logic                o_flag,
    output logic                o_flag_next
);
    import fsm_pkg::*;

    logic [7:0] r_pat;
    logic       r_flag;
    logic       n_flag;

    // prefix up to this byte matches the newest text bytes
    always_comb begin
        n_flag = r_flag;
        if (i_ctrl.restart) begin
            n_flag = 1'b0;
        end else if (i_ctrl.step) begin
            n_flag = i_prev_flag & (i_ctrl.symbol == r_pat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_pat <= i_ctrl.symbol;
        end
    end

    assign o_flag      = r_flag;
    assign o_flag_next = n_flag;

endmodule

// File: src/first_substring_match_core.sv
// ---------------------------------------------------------------------------
// first_substring_match_core
// streaming first-occurrence substring search over a chain of match cells
// ---------------------------------------------------------------------------
// usage
//   input channel: one word per command (clear, append pattern byte, text
//   byte, end of text). a word is taken when i_in_valid is high and
//   o_in_stall is low.
//   output channel: one word (found, position) per end-of-text command,
//   taken when o_out_valid is high and i_out_stall is low.
//   throughput: one input word every cycle while o_in_stall is low. cell k
//   holds pattern byte k and a flag saying the newest k+1 text bytes equal
//   the first k+1 pattern bytes; each text byte moves every flag one cell
//   along, so the window compare is one byte compare per cell per cycle.
//   latency: the result appears on o_out_valid the cycle after the
//   end-of-text word is taken.
//   stall: o_in_stall rises only while a result waits in the output
//   register and the receiver stalls; other words never pile up.
//   reset: synchronous, active low. the pattern is empty, the text restarts
//   and the output register is empty. pattern bytes need no reset since
//   only written entries are ever looked at.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module first_substring_match_core #(
    parameter int MAX_PATTERN = 32,
    parameter int MAX_TEXT    = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fsm_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fsm_pkg::t_out_word o_out_data
);
    import fsm_pkg::*;

    // widths of the pattern length, cell index and text counter
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW = $clog2(MAX_TEXT + 1);
    localparam int SW = (CW > LW) ? CW : LW;
    localparam int PW = (SW > 16) ? SW : 16;

    logic          in_acc;
    logic          is_clear, is_append, is_text, is_end;

    logic [LW-1:0] r_len,   n_len;
    logic [CW-1:0] r_count, n_count;
    logic          r_seen,  n_seen;
    logic [15:0]   r_start, n_start;
    logic          r_out_valid;
    t_out_word     r_out, n_out;

    logic [MAX_PATTERN-1:0] cell_flag;
    logic [MAX_PATTERN-1:0] cell_flag_next;
    t_cell_ctrl             cell_ctrl [MAX_PATTERN];

    logic          hit;
    logic [IW-1:0] last_idx;
    logic [LW-1:0] len_m1;
    logic [CW-1:0] count_step;
    logic [PW-1:0] start_full;

    // hold input only when a waiting result cannot drain
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    assign is_clear  = in_acc && (i_in_data.command == CMD_CLEAR);
    assign is_append = in_acc && (i_in_data.command == CMD_APPEND);
    assign is_text   = in_acc && (i_in_data.command == CMD_TEXT);
    assign is_end    = in_acc && (i_in_data.command == CMD_END);

    // chain of cells, cell 0 always sees a matching empty prefix before it
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic prev;
        if (k == 0) begin : g_head
            assign prev = 1'b1;
        end else begin : g_link
            assign prev = cell_flag[k-1];
        end

        always_comb begin
            cell_ctrl[k].restart = is_clear | is_append | is_end;
            cell_ctrl[k].step    = is_text;
            cell_ctrl[k].load    = is_append && (r_len == LW'(k));
            cell_ctrl[k].symbol  = i_in_data.symbol;
        end

        fsm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (cell_ctrl[k]),
            .i_prev_flag (prev),
            .o_flag      (cell_flag[k]),
            .o_flag_next (cell_flag_next[k])
        );
    end

    // text count after this byte, position saturates at the end of the range
    assign count_step = (r_count < CW'(MAX_TEXT)) ? (r_count + CW'(1)) : r_count;

    // whole pattern matched when the cell of the last pattern byte sets
    assign len_m1     = r_len - LW'(1);
    assign last_idx   = len_m1[IW-1:0];
    assign hit        = is_text && (r_len != '0) && (PW'(count_step) >= PW'(r_len)) &&
                        cell_flag_next[last_idx];
    assign start_full = PW'(count_step) - PW'(r_len);

    always_comb begin
        n_len   = r_len;
        n_count = r_count;
        n_seen  = r_seen;
        n_start = r_start;
        n_out   = r_out;
        if (is_clear) begin
            n_len   = '0;
            n_count = '0;
            n_seen  = 1'b0;
            n_start = '0;
        end else if (is_append) begin
            if (r_len < LW'(MAX_PATTERN)) begin
                n_len = r_len + LW'(1);
            end
            n_count = '0;
            n_seen  = 1'b0;
            n_start = '0;
        end else if (is_text) begin
            n_count = count_step;
            if (!r_seen && hit) begin
                n_seen  = 1'b1;
                n_start = start_full[15:0];
            end
        end else if (is_end) begin
            // empty pattern counts as found at the start
            if (r_len == '0) begin
                n_out.found    = 1'b1;
                n_out.position = '0;
            end else begin
                n_out.found    = r_seen;
                n_out.position = r_seen ? r_start : 16'd0;
            end
            n_count = '0;
            n_seen  = 1'b0;
            n_start = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_count     <= '0;
            r_seen      <= 1'b0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_count <= n_count;
            r_seen  <= n_seen;
            r_start <= n_start;
            if (is_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an end-of-text word always leaves a result behind
    `ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, is_end, r_out_valid)
    // a not-found result carries position zero
    `ASSERT_IMPL(a_miss_pos_zero, i_clk, i_rst_n, r_out_valid && !r_out.found, r_out.position == 16'd0)
    // pattern length never runs past the cell count
    `ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LW'(MAX_PATTERN))
    // a recorded match needs a non-empty pattern
    `ASSERT_IMPL(a_seen_needs_pattern, i_clk, i_rst_n, r_seen, r_len != '0)

endmodule
